[hw/rtl/pds_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pds_pkg
// Shared widths, defaults, register indexes and the stage control record for
// the 2x pyramid reduction block.
// -----------------------------------------------------------------------------
package pds_pkg;

  localparam int PIX_W     = 16;  // Q8.8 input sample
  localparam int HS_W      = 18;  // horizontal 1-2-1 sum
  localparam int OUT_W     = 20;  // Q8.12 result
  localparam int CFG_W     = 12;  // widest configuration register
  localparam int REG_IDX_W = 1;

  localparam int DEF_MAX_WIDTH    = 2048;
  localparam int DEF_MAX_HEIGHT   = 2048;
  localparam int RST_IMAGE_WIDTH  = 640;
  localparam int RST_IMAGE_HEIGHT = 480;
  localparam int MIN_SIZE         = 4;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  // Control travelling with a request from the front stage to the vertical stage
  typedef struct packed {
    logic emit;       // request yields a result
    logic wr_en;      // horizontal sum goes into a row buffer
    logic wr_odd;     // 1: odd row buffer, 0: even row buffer
    logic first_row;
    logic last_row;
    logic row_end;
    logic frame_end;
  } ctrl_t;

endpackage

[hw/rtl/pds_ram.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pds_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module pds_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/pds_front.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pds_front
// Raster counters, pixel history and horizontal 1-2-1 sum; issues the row
// buffer read and holds the request in the stage register until taken.
// -----------------------------------------------------------------------------
module pds_front #(
  parameter int MAX_WIDTH  = pds_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = pds_pkg::DEF_MAX_HEIGHT,
  localparam int SW = $clog2(MAX_WIDTH + 1),
  localparam int SH = $clog2(MAX_HEIGHT + 1),
  localparam int AW = $clog2(MAX_WIDTH / 2)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [pds_pkg::PIX_W-1:0] pixel,
  input  logic                      frame_start,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [SW-1:0]             img_w,
  input  logic [SH-1:0]             img_h,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  output logic                      s1_valid,
  output logic [pds_pkg::HS_W-1:0]  s1_hs,
  output logic [AW-1:0]             s1_addr,
  output pds_pkg::ctrl_t            s1_ctrl,
  input  logic                      s1_go
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0]               col_count;
  logic [RW-1:0]               row_count;
  logic [pds_pkg::PIX_W-1:0]   prev0;
  logic [pds_pkg::PIX_W-1:0]   prev1;

  logic                        accept;
  logic [CW-1:0]               x_cur;
  logic [RW-1:0]               y_cur;
  logic [CW-2:0]               j_full;
  logic [SW-1:0]               j_ext;
  logic [SH-1:0]               i_ext;
  logic [SW-1:0]               ow;
  logic [SH-1:0]               oh;
  logic [SW-1:0]               x_inc;
  logic [SH-1:0]               y_inc;
  logic                        in_col;
  logic                        first_col;
  logic                        last_col;
  logic [pds_pkg::HS_W-1:0]    pa;
  logic [pds_pkg::HS_W-1:0]    pb;
  logic [pds_pkg::HS_W-1:0]    pc;
  logic [pds_pkg::HS_W-1:0]    hs;
  pds_pkg::ctrl_t              ctrl;

  assign in_ready = !s1_valid || s1_go;
  assign accept   = in_valid && in_ready;

  always_comb begin
    x_cur     = frame_start ? '0 : col_count;
    y_cur     = frame_start ? '0 : row_count;
    j_full    = x_cur[CW-1:1];
    j_ext     = SW'(j_full);
    i_ext     = SH'(y_cur[RW-1:1]);
    ow        = img_w >> 1;
    oh        = img_h >> 1;
    x_inc     = SW'(x_cur) + SW'(1);
    y_inc     = SH'(y_cur) + SH'(1);
    in_col    = x_cur[0] && (j_ext < ow);
    first_col = (j_ext == '0);
    last_col  = (j_ext == ow - SW'(1));

    pa = pds_pkg::HS_W'(prev1);
    pb = pds_pkg::HS_W'(prev0);
    pc = pds_pkg::HS_W'(pixel);
    // Missing neighbour at either edge is replaced by the centre
    if (first_col) begin
      hs = pb + (pb << 1) + pc;
    end else if (last_col) begin
      hs = pa + pb + (pb << 1);
    end else begin
      hs = pa + (pb << 1) + pc;
    end

    ctrl.wr_en     = in_col;
    ctrl.wr_odd    = y_cur[0];
    ctrl.emit      = in_col && y_cur[0] && (i_ext < oh);
    ctrl.first_row = (i_ext == '0);
    ctrl.last_row  = (i_ext == oh - SH'(1));
    ctrl.row_end   = last_col;
    ctrl.frame_end = last_col && ctrl.last_row;

    // Only odd columns use the buffers; two odd columns never follow back to back,
    // so a read never meets the pending write at the same entry.
    rd_en   = accept && x_cur[0];
    rd_addr = j_full[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      prev0     <= '0;
      prev1     <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (accept) begin
        prev1 <= prev0;
        prev0 <= pixel;
        if (x_inc >= img_w) begin
          col_count <= '0;
          row_count <= (y_inc >= img_h) ? '0 : y_inc[RW-1:0];
        end else begin
          col_count <= x_inc[CW-1:0];
          row_count <= y_cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hs   <= hs;
      s1_addr <= j_full[AW-1:0];
      s1_ctrl <= ctrl;
    end
  end

endmodule

[hw/rtl/pds_vert.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pds_vert
// Vertical 1-2-1 over buffered row sums, row buffer write-back and the
// output register.
// -----------------------------------------------------------------------------
module pds_vert #(
  parameter int AW = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s1_valid,
  input  logic [pds_pkg::HS_W-1:0]  s1_hs,
  input  logic [AW-1:0]             s1_addr,
  input  pds_pkg::ctrl_t            s1_ctrl,
  output logic                      s1_go,
  input  logic [pds_pkg::HS_W-1:0]  odd_q,
  input  logic [pds_pkg::HS_W-1:0]  even_q,
  output logic                      wr_en_odd,
  output logic                      wr_en_even,
  output logic [AW-1:0]             wr_addr,
  output logic [pds_pkg::HS_W-1:0]  wr_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [pds_pkg::OUT_W-1:0] out_value,
  output logic                      row_end,
  output logic                      frame_end
);

  logic [pds_pkg::OUT_W-1:0] a;
  logic [pds_pkg::OUT_W-1:0] b;
  logic [pds_pkg::OUT_W-1:0] c;
  logic [pds_pkg::OUT_W-1:0] v;
  logic                      advance;

  assign s1_go   = !out_valid || out_ready;
  assign advance = s1_valid && s1_go;

  assign wr_en_odd  = advance && s1_ctrl.wr_en && s1_ctrl.wr_odd;
  assign wr_en_even = advance && s1_ctrl.wr_en && !s1_ctrl.wr_odd;
  assign wr_addr    = s1_addr;
  assign wr_data    = s1_hs;

  always_comb begin
    a = pds_pkg::OUT_W'(odd_q);   // row 2i-1
    b = pds_pkg::OUT_W'(even_q);  // row 2i, centre
    c = pds_pkg::OUT_W'(s1_hs);   // row 2i+1, current
    if (s1_ctrl.first_row) begin
      v = b + (b << 1) + c;
    end else if (s1_ctrl.last_row) begin
      v = a + b + (b << 1);
    end else begin
      v = a + (b << 1) + c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_valid && s1_ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_ctrl.emit) begin
      out_value <= v;
      row_end   <= s1_ctrl.row_end;
      frame_end <= s1_ctrl.frame_end;
    end
  end

endmodule

[hw/rtl/pyramid_downsample_121.sv]
`timescale 1ns / 1ps
// Path: the request that completes a result passes the front stage register (with row
//   buffer read), then the vertical sum into the output register.
// Throughput: one request per cycle; the row buffers take one read and one write
//   each cycle, and the only stall comes from a full output register.
// Reset: counters, pixel history and handshake state cleared, size 640 x 480;
//   the row buffers are not cleared and hold data only once written.
// -----------------------------------------------------------------------------
// pyramid_downsample_121
// 2x pyramid reduction with a separable 1-2-1 filter on a raster pixel stream.
// -----------------------------------------------------------------------------
module pyramid_downsample_121 #(
  parameter int MAX_WIDTH  = pds_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = pds_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [pds_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [pds_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pds_pkg::PIX_W-1:0]     pixel,
  input  logic                          frame_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pds_pkg::OUT_W-1:0]     out_value,
  output logic                          row_end,
  output logic                          frame_end
);

  localparam int SW    = $clog2(MAX_WIDTH + 1);
  localparam int SH    = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int W_RST = (pds_pkg::RST_IMAGE_WIDTH > MAX_WIDTH) ?
                         MAX_WIDTH : pds_pkg::RST_IMAGE_WIDTH;
  localparam int H_RST = (pds_pkg::RST_IMAGE_HEIGHT > MAX_HEIGHT) ?
                         MAX_HEIGHT : pds_pkg::RST_IMAGE_HEIGHT;

  logic [SW-1:0]              img_w;
  logic [SH-1:0]              img_h;
  logic [SW-1:0]              w_clamped;
  logic [SH-1:0]              h_clamped;

  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic                       s1_valid;
  logic [pds_pkg::HS_W-1:0]   s1_hs;
  logic [AW-1:0]              s1_addr;
  pds_pkg::ctrl_t             s1_ctrl;
  logic                       s1_go;
  logic [pds_pkg::HS_W-1:0]   odd_q;
  logic [pds_pkg::HS_W-1:0]   even_q;
  logic                       wr_en_odd;
  logic                       wr_en_even;
  logic [AW-1:0]              wr_addr;
  logic [pds_pkg::HS_W-1:0]   wr_data;

  // Sizes are clamped on write, so the datapath only ever sees legal values
  always_comb begin
    if (int'(cfg_data) < pds_pkg::MIN_SIZE) begin
      w_clamped = SW'(pds_pkg::MIN_SIZE);
    end else if (int'(cfg_data) > MAX_WIDTH) begin
      w_clamped = SW'(MAX_WIDTH);
    end else begin
      w_clamped = SW'(cfg_data);
    end
    if (int'(cfg_data) < pds_pkg::MIN_SIZE) begin
      h_clamped = SH'(pds_pkg::MIN_SIZE);
    end else if (int'(cfg_data) > MAX_HEIGHT) begin
      h_clamped = SH'(MAX_HEIGHT);
    end else begin
      h_clamped = SH'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= SW'(W_RST);
      img_h <= SH'(H_RST);
    end else if (cfg_wr_en) begin
      unique case (pds_pkg::reg_idx_t'(cfg_index))
        pds_pkg::REG_IMAGE_WIDTH:  img_w <= w_clamped;
        pds_pkg::REG_IMAGE_HEIGHT: img_h <= h_clamped;
        default: ;
      endcase
    end
  end

  pds_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel       (pixel),
    .frame_start (frame_start),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .img_w       (img_w),
    .img_h       (img_h),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .s1_valid    (s1_valid),
    .s1_hs       (s1_hs),
    .s1_addr     (s1_addr),
    .s1_ctrl     (s1_ctrl),
    .s1_go       (s1_go)
  );

  pds_ram #(
    .WIDTH (pds_pkg::HS_W),
    .DEPTH (DEPTH)
  ) u_odd_rows (
    .clk     (clk),
    .wr_en   (wr_en_odd),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (odd_q)
  );

  pds_ram #(
    .WIDTH (pds_pkg::HS_W),
    .DEPTH (DEPTH)
  ) u_even_rows (
    .clk     (clk),
    .wr_en   (wr_en_even),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (even_q)
  );

  pds_vert #(
    .AW (AW)
  ) u_vert (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1_hs      (s1_hs),
    .s1_addr    (s1_addr),
    .s1_ctrl    (s1_ctrl),
    .s1_go      (s1_go),
    .odd_q      (odd_q),
    .even_q     (even_q),
    .wr_en_odd  (wr_en_odd),
    .wr_en_even (wr_en_even),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .row_end    (row_end),
    .frame_end  (frame_end)
  );

  // A buffer read never lands on the entry being written back
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    rd_en && (wr_en_odd || wr_en_even) |-> rd_addr != wr_addr)
    else $error("row buffer read and write hit the same entry");

  // Input stalls only behind a full, blocked output register
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // Last pixel of the frame is also the last of its row
  a_frame_end_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> row_end)
    else $error("frame end without row end");

endmodule
